// ===== sv/assert_macros.svh =====
// Assertion macros used by the port-level checker, pcc_checker.
// Plain concurrent property wrappers, no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/pcc_pkg.sv =====
// Shared types and constants for the polygon convexity check.
// No dependencies.
package pcc_pkg;

  // Saturating vertex count codes
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_FULL = 2'd3;

  // Points carried per item: older, newer, current, first, second
  localparam int NUM_POINTS  = 5;
  // Corners per item: (older,newer,cur), (newer,cur,first), (cur,first,second)
  localparam int NUM_CORNERS = 3;

  typedef struct packed {
    logic last;          // item closes the polygon
    logic corner;        // at least two vertices before this one
    logic first_corner;  // this item completes the first corner
  } pcc_flags_t;

endpackage

// ===== sv/pcc_front.sv =====
// Vertex history and input register stage.
// Depends on pcc_pkg.
module pcc_front import pcc_pkg::*; #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] vertex_x,
  input  logic signed [COORD_BITS-1:0] vertex_y,
  input  logic                         last_vertex,
  output logic                         s1_valid,
  input  logic                         s1_ready,
  output pcc_flags_t                   s1_flags,
  output logic signed [COORD_BITS-1:0] s1_px [NUM_POINTS],
  output logic signed [COORD_BITS-1:0] s1_py [NUM_POINTS]
);

  logic signed [COORD_BITS-1:0] first_x, first_y, second_x, second_y;
  logic signed [COORD_BITS-1:0] older_x, older_y, newer_x, newer_y;
  logic [1:0]                   seen_count;
  logic [1:0]                   seen_count_next;
  logic                         accept;
  pcc_flags_t                   flags_next;

  assign in_ready = !s1_valid || s1_ready;
  assign accept   = in_valid && in_ready;

  assign seen_count_next = last_vertex ? CNT_NONE :
                           (seen_count == CNT_FULL) ? CNT_FULL : seen_count + 2'd1;

  always_comb begin
    flags_next.last         = last_vertex;
    flags_next.corner       = (seen_count == CNT_TWO) || (seen_count == CNT_FULL);
    flags_next.first_corner = (seen_count == CNT_TWO);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_count <= CNT_NONE;
      s1_valid   <= 1'b0;
    end else begin
      if (accept) begin
        seen_count <= seen_count_next;
      end
      if (in_ready) begin
        s1_valid <= in_valid;
      end
    end
  end

  // history and operand registers, no reset needed: read only once written
  always_ff @(posedge clk) begin
    if (accept) begin
      case (seen_count)
        CNT_NONE: begin
          first_x <= vertex_x;
          first_y <= vertex_y;
        end
        CNT_ONE: begin
          second_x <= vertex_x;
          second_y <= vertex_y;
        end
        default: ;
      endcase
      older_x  <= newer_x;
      older_y  <= newer_y;
      newer_x  <= vertex_x;
      newer_y  <= vertex_y;
      s1_flags <= flags_next;
      s1_px[0] <= older_x;
      s1_py[0] <= older_y;
      s1_px[1] <= newer_x;
      s1_py[1] <= newer_y;
      s1_px[2] <= vertex_x;
      s1_py[2] <= vertex_y;
      s1_px[3] <= first_x;
      s1_py[3] <= first_y;
      s1_px[4] <= second_x;
      s1_py[4] <= second_y;
    end
  end

endmodule

// ===== sv/pcc_mul.sv =====
// Edge differences and cross product terms for three corners, registered.
// Depends on pcc_pkg.
module pcc_mul import pcc_pkg::*; #(
  parameter int COORD_BITS = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s1_valid,
  output logic                             s1_ready,
  input  pcc_flags_t                       s1_flags,
  input  logic signed [COORD_BITS-1:0]     s1_px [NUM_POINTS],
  input  logic signed [COORD_BITS-1:0]     s1_py [NUM_POINTS],
  output logic                             s2_valid,
  input  logic                             s2_ready,
  output pcc_flags_t                       s2_flags,
  output logic signed [2*COORD_BITS+1:0]   s2_prod_p [NUM_CORNERS],
  output logic signed [2*COORD_BITS+1:0]   s2_prod_q [NUM_CORNERS]
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  logic signed [DW-1:0] dx1 [NUM_CORNERS];
  logic signed [DW-1:0] dy1 [NUM_CORNERS];
  logic signed [DW-1:0] dx2 [NUM_CORNERS];
  logic signed [DW-1:0] dy2 [NUM_CORNERS];
  logic signed [PW-1:0] prod_p_next [NUM_CORNERS];
  logic signed [PW-1:0] prod_q_next [NUM_CORNERS];
  logic                 load;

  assign s1_ready = !s2_valid || s2_ready;
  assign load     = s1_valid && s1_ready;

  // corner k spans points k, k+1, k+2; z = dx1*dy2 - dy1*dx2
  for (genvar k = 0; k < NUM_CORNERS; k++) begin : g_corner
    assign dx1[k] = $signed({s1_px[k+1][COORD_BITS-1], s1_px[k+1]})
                  - $signed({s1_px[k][COORD_BITS-1],   s1_px[k]});
    assign dy1[k] = $signed({s1_py[k+1][COORD_BITS-1], s1_py[k+1]})
                  - $signed({s1_py[k][COORD_BITS-1],   s1_py[k]});
    assign dx2[k] = $signed({s1_px[k+2][COORD_BITS-1], s1_px[k+2]})
                  - $signed({s1_px[k+1][COORD_BITS-1], s1_px[k+1]});
    assign dy2[k] = $signed({s1_py[k+2][COORD_BITS-1], s1_py[k+2]})
                  - $signed({s1_py[k+1][COORD_BITS-1], s1_py[k+1]});
    assign prod_p_next[k] = dx1[k] * dy2[k];
    assign prod_q_next[k] = dy1[k] * dx2[k];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s2_flags <= s1_flags;
      for (int k = 0; k < NUM_CORNERS; k++) begin
        s2_prod_p[k] <= prod_p_next[k];
        s2_prod_q[k] <= prod_q_next[k];
      end
    end
  end

endmodule

// ===== sv/pcc_judge.sv =====
// Corner sign compare, running verdict and result register.
// Depends on pcc_pkg.
module pcc_judge import pcc_pkg::*; #(
  parameter int COORD_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s2_valid,
  output logic                           s2_ready,
  input  pcc_flags_t                     s2_flags,
  input  logic signed [2*COORD_BITS+1:0] s2_prod_p [NUM_CORNERS],
  input  logic signed [2*COORD_BITS+1:0] s2_prod_q [NUM_CORNERS],
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           is_convex,
  output logic                           too_few_vertices
);

  logic                   first_sign_positive;
  logic                   mismatch_seen;
  logic [NUM_CORNERS-1:0] positive;
  logic                   sign_ref;
  logic                   mismatch_next;
  logic                   take;

  // zero product counts as not positive
  for (genvar k = 0; k < NUM_CORNERS; k++) begin : g_sign
    assign positive[k] = s2_prod_p[k] > s2_prod_q[k];
  end

  // only items that close a polygon need the output slot
  assign s2_ready = !s2_flags.last || !out_valid || out_ready;
  assign take     = s2_valid && s2_ready;

  always_comb begin
    sign_ref      = s2_flags.first_corner ? positive[0] : first_sign_positive;
    mismatch_next = mismatch_seen;
    if (s2_flags.corner && !s2_flags.first_corner && (positive[0] != first_sign_positive)) begin
      mismatch_next = 1'b1;
    end
    // wrap-around corners on the closing vertex
    if (s2_flags.last && s2_flags.corner &&
        ((positive[1] != sign_ref) || (positive[2] != sign_ref))) begin
      mismatch_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_sign_positive <= 1'b0;
      mismatch_seen       <= 1'b0;
      out_valid           <= 1'b0;
    end else begin
      if (take) begin
        if (s2_flags.last) begin
          first_sign_positive <= 1'b0;
          mismatch_seen       <= 1'b0;
        end else begin
          first_sign_positive <= sign_ref;
          mismatch_seen       <= mismatch_next;
        end
      end
      if (take && s2_flags.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && s2_flags.last) begin
      is_convex        <= s2_flags.corner && !mismatch_next;
      too_few_vertices <= !s2_flags.corner;
    end
  end

endmodule

// ===== sv/polygon_convexity_check.sv =====
// Polygon convexity check: one vertex per item, one result per polygon.
// A closing vertex passes the input, product and result registers in turn.
// Throughput: one vertex per cycle; each stage takes a new item every cycle
// unless the stage after it holds an item and is stalled by back-pressure.
// Reset clears the vertex count, the running sign verdict and all valid bits.
// Depends on pcc_pkg, pcc_front, pcc_mul and pcc_judge.
module polygon_convexity_check import pcc_pkg::*; #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] vertex_x,
  input  logic signed [COORD_BITS-1:0] vertex_y,
  input  logic                         last_vertex,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         is_convex,
  output logic                         too_few_vertices
);

  logic                           s1_valid;
  logic                           s1_ready;
  pcc_flags_t                     s1_flags;
  logic signed [COORD_BITS-1:0]   s1_px [NUM_POINTS];
  logic signed [COORD_BITS-1:0]   s1_py [NUM_POINTS];
  logic                           s2_valid;
  logic                           s2_ready;
  pcc_flags_t                     s2_flags;
  logic signed [2*COORD_BITS+1:0] s2_prod_p [NUM_CORNERS];
  logic signed [2*COORD_BITS+1:0] s2_prod_q [NUM_CORNERS];

  pcc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .vertex_x    (vertex_x),
    .vertex_y    (vertex_y),
    .last_vertex (last_vertex),
    .s1_valid    (s1_valid),
    .s1_ready    (s1_ready),
    .s1_flags    (s1_flags),
    .s1_px       (s1_px),
    .s1_py       (s1_py)
  );

  pcc_mul #(.COORD_BITS(COORD_BITS)) u_mul (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .s1_ready  (s1_ready),
    .s1_flags  (s1_flags),
    .s1_px     (s1_px),
    .s1_py     (s1_py),
    .s2_valid  (s2_valid),
    .s2_ready  (s2_ready),
    .s2_flags  (s2_flags),
    .s2_prod_p (s2_prod_p),
    .s2_prod_q (s2_prod_q)
  );

  pcc_judge #(.COORD_BITS(COORD_BITS)) u_judge (
    .clk              (clk),
    .rst              (rst),
    .s2_valid         (s2_valid),
    .s2_ready         (s2_ready),
    .s2_flags         (s2_flags),
    .s2_prod_p        (s2_prod_p),
    .s2_prod_q        (s2_prod_q),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .is_convex        (is_convex),
    .too_few_vertices (too_few_vertices)
  );

endmodule

// ===== sv/pcc_checker.sv =====
// Port-level checks for polygon_convexity_check, attached by bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module pcc_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic last_vertex,
  input logic out_valid,
  input logic out_ready,
  input logic is_convex,
  input logic too_few_vertices
);

  // closing vertices accepted whose result has not yet been taken
  logic [2:0] pending;
  logic       close_in;
  logic       result_out;

  assign close_in   = in_valid && in_ready && last_vertex;
  assign result_out = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 3'd0;
    end else if (close_in && !result_out) begin
      pending <= pending + 3'd1;
    end else if (!close_in && result_out) begin
      pending <= pending - 3'd1;
    end
  end

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable({is_convex, too_few_vertices}))
  `ASSERT_IMPLY(a_flags_exclusive, clk, rst, out_valid, !(is_convex && too_few_vertices))
  `ASSERT_IMPLY(a_result_has_polygon, clk, rst, out_valid, pending != 3'd0)

endmodule

bind polygon_convexity_check pcc_checker u_pcc_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .last_vertex      (last_vertex),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .is_convex        (is_convex),
  .too_few_vertices (too_few_vertices)
);

// ===== tb/sv/polygon_convexity_checker.sv =====
// Checker for the polygon convexity block: watches both channels, predicts
// one verdict per closed polygon and compares it with what comes out.
// Depends on pcc_pkg for the vertex count codes.
module polygon_convexity_checker import pcc_pkg::*; #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] vertex_x,
  input  logic signed [COORD_BITS-1:0] vertex_y,
  input  logic                         last_vertex,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic                         is_convex,
  input  logic                         too_few_vertices,
  output int                           fail_count,
  output int                           verdicts_pending
);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct {
    logic convex;
    logic too_few;
  } verdict_t;

  // running polygon state
  coord_t     head_x, head_y, next_x, next_y;
  coord_t     back2_x, back2_y, back1_x, back1_y;
  logic [1:0] seen;
  logic       ref_left;
  logic       sign_broken;

  verdict_t   verdict_q[$];

  // exact z of (B - A) x (C - B) > 0; 25-bit deltas, products fit easily
  function automatic logic turns_left(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                                      coord_t cx, coord_t cy);
    longint dx1, dy1, dx2, dy2;
    dx1 = longint'(bx) - longint'(ax);
    dy1 = longint'(by) - longint'(ay);
    dx2 = longint'(cx) - longint'(bx);
    dy2 = longint'(cy) - longint'(by);
    return (dx1 * dy2) > (dy1 * dx2);
  endfunction

  task automatic tally_corner(logic left, logic is_ref);
    if (is_ref) begin
      ref_left = left;
    end else if (left != ref_left) begin
      sign_broken = 1'b1;
    end
  endtask

  task automatic clear_polygon();
    head_x = '0; head_y = '0; next_x = '0; next_y = '0;
    back2_x = '0; back2_y = '0; back1_x = '0; back1_y = '0;
    seen = CNT_NONE;
    ref_left = 1'b0;
    sign_broken = 1'b0;
  endtask

  task automatic absorb_vertex(coord_t x, coord_t y, logic closes);
    verdict_t v;
    case (seen)
      CNT_NONE: begin
        head_x = x;
        head_y = y;
      end
      CNT_ONE: begin
        next_x = x;
        next_y = y;
      end
      default: begin
        tally_corner(turns_left(back2_x, back2_y, back1_x, back1_y, x, y), seen == CNT_TWO);
      end
    endcase
    back2_x = back1_x;
    back2_y = back1_y;
    back1_x = x;
    back1_y = y;
    if (seen != CNT_FULL) seen = seen + 2'd1;
    if (closes) begin
      v.too_few = (seen != CNT_FULL);
      if (!v.too_few) begin
        // wrap-around corners
        tally_corner(turns_left(back2_x, back2_y, back1_x, back1_y, head_x, head_y), 1'b0);
        tally_corner(turns_left(back1_x, back1_y, head_x, head_y, next_x, next_y), 1'b0);
      end
      v.convex = !v.too_few && !sign_broken;
      verdict_q.insert(verdict_q.size(), v);
      clear_polygon();
    end
  endtask

  always @(posedge clk) begin
    int       errs_now;
    verdict_t want;
    errs_now = 0;
    if (rst) begin
      clear_polygon();
      verdict_q.delete();
    end else begin
      if (in_valid && in_ready) absorb_vertex(vertex_x, vertex_y, last_vertex);
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual convex=%0b too_few=%0b",
                   $time, is_convex, too_few_vertices);
          errs_now++;
        end else begin
          want = verdict_q.pop_front();
          if (is_convex !== want.convex) begin
            $display("%0t: is_convex mismatch: expected %0b, actual %0b",
                     $time, want.convex, is_convex);
            errs_now++;
          end
          if (too_few_vertices !== want.too_few) begin
            $display("%0t: too_few_vertices mismatch: expected %0b, actual %0b",
                     $time, want.too_few, too_few_vertices);
            errs_now++;
          end
        end
      end
    end
    fail_count <= fail_count + errs_now;
    verdicts_pending <= verdict_q.size();
  end

endmodule

// ===== tb/sv/tb_polygon_convexity_check.sv =====
// Testbench top for polygon_convexity_check: drives vertex streams with random
// idling and a long output stall, and reports the verdict of the checker.
// Depends on polygon_convexity_check and polygon_convexity_checker.
module tb_polygon_convexity_check;

  localparam int  COORD_BITS     = 24;
  localparam int  COORD_MIN      = -8388608;
  localparam int  COORD_MAX      = 8388607;
  localparam int  RANDOM_ITEMS   = 500;
  localparam int  QUIET_TAIL     = 100;
  localparam int  HOLD_CYCLES    = 200;
  localparam int  WATCHDOG_LIMIT = 2000;
  localparam real PI             = 3.14159265358979;

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_ready;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic                         last_vertex;
  logic                         out_valid;
  logic                         out_ready;
  logic                         is_convex;
  logic                         too_few_vertices;

  int fail_count;
  int verdicts_pending;
  int items_sent;
  int idle_cycles;
  bit tx_idle_on;
  bit rx_idle_on;
  bit hold_go;
  bit hold_taken;

  polygon_convexity_check #(.COORD_BITS(COORD_BITS)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .vertex_x(vertex_x), .vertex_y(vertex_y), .last_vertex(last_vertex),
    .out_valid(out_valid), .out_ready(out_ready),
    .is_convex(is_convex), .too_few_vertices(too_few_vertices)
  );

  polygon_convexity_checker #(.COORD_BITS(COORD_BITS)) u_verdict_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .vertex_x(vertex_x), .vertex_y(vertex_y), .last_vertex(last_vertex),
    .out_valid(out_valid), .out_ready(out_ready),
    .is_convex(is_convex), .too_few_vertices(too_few_vertices),
    .fail_count(fail_count), .verdicts_pending(verdicts_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // nothing accepted on either channel for too long ends the run
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_polygon_convexity_check: FAIL");
        $finish;
      end
    end
  end

  // receiver: random stall bursts, plus one long hold on request
  initial begin
    hold_taken = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 4) - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  function automatic int pick_extreme();
    case ($urandom_range(0, 4))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2:       return 0;
      3:       return -1;
      default: return 1;
    endcase
  endfunction

  task automatic emit(int x, int y, bit closes);
    @(negedge clk);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid    = 1'b1;
    vertex_x    = x[COORD_BITS-1:0];
    vertex_y    = y[COORD_BITS-1:0];
    last_vertex = closes;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  initial begin
    int  kind, n, r, cx, cy, dent;
    int  xs[8];
    int  ys[8];
    real phi, ang, dir;
    bit  hold_done;

    rst = 1'b1;
    in_valid = 1'b0;
    vertex_x = '0;
    vertex_y = '0;
    last_vertex = 1'b0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    hold_go = 1'b0;
    hold_done = 1'b0;
    items_sent = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // single vertex and two vertices: too few
    emit(COORD_MIN, COORD_MAX, 1'b1);
    emit(0, 0, 1'b0);
    emit(COORD_MAX, COORD_MIN, 1'b1);
    // counter-clockwise and clockwise triangles
    emit(0, 0, 1'b0);  emit(10, 0, 1'b0);  emit(0, 10, 1'b1);
    emit(0, 0, 1'b0);  emit(0, 10, 1'b0);  emit(10, 0, 1'b1);
    // full-range square, largest products
    emit(COORD_MIN, COORD_MIN, 1'b0);
    emit(COORD_MAX, COORD_MIN, 1'b0);
    emit(COORD_MAX, COORD_MAX, 1'b0);
    emit(COORD_MIN, COORD_MAX, 1'b1);
    // concave quad
    emit(0, 0, 1'b0);  emit(10, 0, 1'b0);  emit(2, 2, 1'b0);  emit(0, 10, 1'b1);
    // collinear, all corners zero
    emit(0, 0, 1'b0);  emit(1, 1, 1'b0);  emit(2, 2, 1'b1);
    // repeated vertex
    emit(5, 5, 1'b0);  emit(5, 5, 1'b0);  emit(5, 5, 1'b0);  emit(5, 5, 1'b1);

    while (items_sent < 24 + RANDOM_ITEMS) begin
      if (!hold_done && items_sent > 150) begin
        // stall the output while a run of one-vertex polygons piles up results
        hold_go = 1'b1;
        hold_done = 1'b1;
        repeat (40) emit(pick_extreme(), pick_extreme(), 1'b1);
      end
      if (items_sent > 24 + RANDOM_ITEMS - QUIET_TAIL) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      kind = $urandom_range(0, 9);
      if (kind <= 3 || kind == 6) begin
        // regular polygon, optionally dented at one vertex
        n = $urandom_range(3, 8);
        r = (kind == 1) ? $urandom_range(1, 20) : $urandom_range(1, 4000000);
        cx = $urandom_range(0, 8000000) - 4000000;
        cy = $urandom_range(0, 8000000) - 4000000;
        phi = $urandom_range(0, 6283) / 1000.0;
        dir = $urandom_range(0, 1) ? 1.0 : -1.0;
        for (int k = 0; k < n; k++) begin
          ang = phi + dir * 2.0 * PI * k / n;
          xs[k] = cx + $rtoi(r * $cos(ang));
          ys[k] = cy + $rtoi(r * $sin(ang));
        end
        if (kind == 6) begin
          dent = $urandom_range(0, n - 1);
          xs[dent] = cx;
          ys[dent] = cy;
        end
        for (int k = 0; k < n; k++) emit(xs[k], ys[k], k == n - 1);
      end else begin
        case (kind)
          7:       n = $urandom_range(1, 2);
          8:       n = $urandom_range(3, 5);
          default: n = $urandom_range(1, 6);
        endcase
        for (int k = 0; k < n; k++) begin
          case (kind)
            4:       emit($urandom_range(0, 16777215) + COORD_MIN,
                          $urandom_range(0, 16777215) + COORD_MIN, k == n - 1);
            5:       emit($urandom_range(0, 4) - 2, $urandom_range(0, 4) - 2, k == n - 1);
            8:       emit(pick_extreme(), pick_extreme(), k == n - 1);
            9:       emit($urandom, $urandom, k == n - 1);
            default: emit($urandom, $urandom, k == n - 1);
          endcase
        end
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (verdicts_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_polygon_convexity_check: PASS");
    end else begin
      $display("tb_polygon_convexity_check: FAIL");
    end
    $finish;
  end

endmodule
